// File: hw/rtl/sbbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbbc_pkg
// Constants and register codes for the slew/brightness biquad cascade.
// ----------------------------------------------------------------------------
package sbbc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int TAN_W      = 32;
	localparam int BRIGHT_W   = 10;
	localparam int WET_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 2'd1;

	localparam logic [TAN_W-1:0]    TAN_RESET  = 32'd1677722;
	localparam logic [TAN_W-1:0]    TAN_MAX    = 32'd2670168073;
	localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 10'd1000;

	// serial arithmetic unit used by coefficient derivation
	localparam int UA_W      = 41;
	localparam int UB_W      = 63;
	localparam int UACC_W    = 81;
	localparam int UCNT_W    = 6;
	localparam int MUL_STEPS = 40;
	localparam int DIV_STEPS = 63;

	localparam logic [UA_W-1:0] ONE_Q23  = 41'd8388608;
	localparam int              TRIM_Q24 = 38630967;
	localparam logic [16:0]     WET_ONE  = 17'd32768;

	// ceil(2^35 / 1000): (n * WET_RECIP) >> 35 equals n / 1000 for any 25-bit n
	localparam logic [25:0]     WET_RECIP = 26'd34359739;

	// 1/Q in Q30 for the four biquads
	function automatic logic [31:0] inv_q(input logic [1:0] idx);
		logic [31:0] r;
		case (idx)
			2'd0:    r = 32'd477860067;
			2'd1:    r = 32'd1338934154;
			2'd2:    r = 32'd1934815911;
			default: r = 32'd2147483648;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/slew_brightness_biquad_cascade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_brightness_biquad_cascade
// Three brightness-staged lowpass/slew stages and a final lowpass blend on a
// mono sample stream, one shared multiplier, history held in block memory.
// ----------------------------------------------------------------------------
// One item in gives one item out; the block takes no new item until the last
// one has been loaded into the output register. Each engaged slew stage runs a
// biquad, the slew and the blend, a disengaged one is skipped, and the final
// lowpass runs only when the first stage is engaged. The processing time is set
// by the one shared multiplier and the single read port of the history memory.
// After reset or a write to the cutoff or brightness register, the next item
// first re-derives the coefficients and wet amounts with a bit-serial multiply
// and divide unit. A finished item waits in the output register while the
// next item is accepted and processed. Register writes are taken only while
// the block is idle.
module slew_brightness_biquad_cascade #(
	parameter int SAMPLE_BITS   = 24,
	parameter int INTERNAL_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SAMPLE_BITS-1:0]          in_sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [SAMPLE_BITS-1:0]          out_sample,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sbbc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sbbc_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import sbbc_pkg::*;

	localparam int FRAC = SAMPLE_BITS - 1;
	localparam int IB   = INTERNAL_BITS;
	localparam int CW   = FRAC + 4;
	localparam int MA   = (CW > 28) ? CW : 28;
	localparam int MB   = IB + 2;
	localparam int PW   = MA + MB;
	localparam int AW   = PW + 2;
	localparam int SH   = FRAC - 23;
	localparam int SHL  = (SH > 0) ? SH : 0;
	localparam int SHR  = (SH < 0) ? -SH : 0;
	localparam int VW   = 45;
	localparam int CVW  = VW + SHL + 1;
	localparam int HD   = 20;
	localparam int HAW  = 5;
	localparam int CD   = 12;
	localparam int CAW  = 4;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DK2   = 5'd1;
	localparam logic [4:0] S_DKQ   = 5'd2;
	localparam logic [4:0] S_DNORM = 5'd3;
	localparam logic [4:0] S_DSC   = 5'd4;
	localparam logic [4:0] S_DWET  = 5'd5;
	localparam logic [4:0] S_STG   = 5'd6;
	localparam logic [4:0] S_RD    = 5'd7;
	localparam logic [4:0] S_M0    = 5'd8;
	localparam logic [4:0] S_M1    = 5'd9;
	localparam logic [4:0] S_M2    = 5'd10;
	localparam logic [4:0] S_M3    = 5'd11;
	localparam logic [4:0] S_Y     = 5'd12;
	localparam logic [4:0] S_SL    = 5'd13;
	localparam logic [4:0] S_SL2   = 5'd14;
	localparam logic [4:0] S_B1    = 5'd15;
	localparam logic [4:0] S_B2    = 5'd16;
	localparam logic [4:0] S_B3    = 5'd17;
	localparam logic [4:0] S_B4    = 5'd18;
	localparam logic [4:0] S_FIN   = 5'd19;

	function automatic logic signed [IB-1:0] sat_ib(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = {{(AW-IB+1){1'b0}}, {(IB-1){1'b1}}};
		lo = ~hi;
		if (v > hi) return hi[IB-1:0];
		else if (v < lo) return lo[IB-1:0];
		else return v[IB-1:0];
	endfunction

	function automatic logic signed [AW-1:0] rshr(input logic signed [AW-1:0] v, input int s);
		logic signed [AW-1:0] half;
		half = AW'(1) << (s - 1);
		return (v + half) >>> s;
	endfunction

	// control
	logic [4:0]            state_q;
	logic [1:0]            st_q, di_q, sc_q;
	logic [2:0]            rc_q, wr_cnt_q;
	logic                  ph_q, pending_q, out_valid_q, wr_act_q;
	logic [TAN_W-1:0]      tan_q;
	logic [BRIGHT_W-1:0]   bright_q;
	logic [WET_W-1:0]      wet_amt_q [3];

	// datapath
	logic signed [IB-1:0]  v_q, bq_in_q, y_q, wet_q, prev_q;
	logic signed [IB-1:0]  h_q [4];
	logic signed [CW-1:0]  c_q [3];
	logic signed [AW-1:0]  acc_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic [39:0]           k2_q, norm_q;
	logic [33:0]           kq_q;

	// serial unit
	logic                  u_busy_q, u_div_q;
	logic [UCNT_W-1:0]     u_cnt_q;
	logic [UA_W-1:0]       u_a_q;
	logic [UB_W-1:0]       u_b_q;
	logic [UACC_W-1:0]     u_acc_q;
	logic                  u_start, u_div, u_done;
	logic [UA_W-1:0]       u_a;
	logic [UB_W-1:0]       u_b;

	// memories
	logic [IB-1:0]         hist_mem [HD];
	logic [HD-1:0]         hist_vld_q;
	logic [IB-1:0]         hist_rd_q;
	logic                  hist_rd_vld_q;
	logic [HAW-1:0]        hist_raddr, hist_waddr;
	logic [IB-1:0]         hist_wdata;
	logic                  hist_we;
	logic signed [IB-1:0]  hist_rdata;
	logic [CW-1:0]         coef_mem [CD];
	logic [CW-1:0]         coef_rd_q;
	logic [CAW-1:0]        coef_raddr, coef_waddr;
	logic [CW-1:0]         coef_wdata;
	logic                  coef_we;

	logic [WET_W-1:0]      w_cur;
	logic signed [MA-1:0]  mul_a;
	logic signed [MB-1:0]  mul_b;
	logic signed [MB-1:0]  sum_b;
	logic signed [PW-1:0]  prod_w;
	logic [2:0]            rcm;
	logic                  in_acc, wr_last;

	// derivation helpers
	logic [TAN_W-1:0]      k_sat;
	logic [UA_W-1:0]       d_w;
	logic signed [41:0]    num_w;
	logic [UA_W-1:0]       mag_w;
	logic [UACC_W-1:0]     psum_w;
	logic [41:0]           p_w;
	logic signed [VW-1:0]  val_w;
	logic signed [CVW-1:0] cv_ext, cv_res;
	logic [BRIGHT_W-1:0]   b_clip, tw;
	logic [11:0]           t3;
	logic [24:0]           wnum;
	logic [50:0]           wprod;

	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_sample = out_q;
	assign in_acc    = in_valid && in_ready;
	assign u_done    = ph_q && !u_busy_q;

	always_comb begin
		case (st_q)
			2'd1:    w_cur = wet_amt_q[1];
			2'd2:    w_cur = wet_amt_q[2];
			default: w_cur = wet_amt_q[0];
		endcase
	end

	// ---------------- coefficient derivation math ----------------
	always_comb begin
		k_sat  = (tan_q > TAN_MAX) ? TAN_MAX : tan_q;
		d_w    = ONE_Q23 + UA_W'(kq_q) + UA_W'(k2_q);
		case (sc_q)
			2'd0:    num_w = $signed({2'b00, k2_q});
			2'd1:    num_w = $signed({2'b00, k2_q}) - $signed({1'b0, ONE_Q23});
			default: num_w = $signed({1'b0, ONE_Q23}) - $signed({8'd0, kq_q})
				+ $signed({2'b00, k2_q});
		endcase
		mag_w  = (num_w < 0) ? UA_W'(-num_w) : UA_W'(num_w);
		psum_w = u_acc_q + (UACC_W'(1) << 38);
		p_w    = psum_w[80:39];
		val_w  = (num_w < 0) ? -$signed({3'b000, p_w}) : $signed({3'b000, p_w});
		if (sc_q == 2'd1) val_w = val_w <<< 1;
		cv_ext = CVW'(val_w) <<< SHL;
		cv_res = (cv_ext + ((CVW'(1) << SHR) >> 1)) >>> SHR;
		coef_wdata = cv_res[CW-1:0];
		coef_waddr = CAW'({di_q, 1'b0}) + CAW'(di_q) + CAW'(sc_q);
		coef_we    = (state_q == S_DSC) && u_done;

		b_clip = (bright_q > BRIGHT_MAX) ? BRIGHT_MAX : bright_q;
		t3     = 12'd3 * {2'b00, b_clip};
		case (sc_q)
			2'd0:    tw = (t3 < 12'd1000) ? t3[9:0] : BRIGHT_MAX;
			2'd1:    tw = (t3 < 12'd1000) ? '0 : (t3 < 12'd2000) ? 10'(t3 - 12'd1000)
				: BRIGHT_MAX;
			default: tw = (t3 < 12'd2000) ? '0 : 10'(t3 - 12'd2000);
		endcase
		wnum  = {tw, 15'd0} + 25'd500;
		// divide by 1000 through the reciprocal
		wprod = 51'(wnum) * 51'(WET_RECIP);
	end

	always_comb begin
		u_start = !ph_q && (state_q == S_DK2 || state_q == S_DKQ || state_q == S_DNORM
			|| state_q == S_DSC);
		u_div = 1'b0;
		u_a   = UA_W'(k_sat);
		u_b   = UB_W'(k_sat);
		case (state_q)
			S_DKQ:   u_b = UB_W'(inv_q(di_q));
			S_DNORM: begin
				u_div = 1'b1;
				u_a   = d_w;
				u_b   = {1'b1, 62'd0};
			end
			S_DSC: begin
				u_a = mag_w;
				u_b = UB_W'(norm_q);
			end
			default: ;
		endcase
	end

	// bit-serial multiply (MSB first) and restoring divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_busy_q <= 1'b0;
		end else if (u_start) begin
			u_busy_q <= 1'b1;
		end else if (u_busy_q && u_cnt_q == '0) begin
			u_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic [41:0] trial;
		trial = {u_acc_q[40:0], u_b_q[62]};
		if (u_start) begin
			u_div_q <= u_div;
			u_cnt_q <= u_div ? UCNT_W'(DIV_STEPS - 1) : UCNT_W'(MUL_STEPS - 1);
			u_a_q   <= u_a;
			u_b_q   <= u_b;
			u_acc_q <= '0;
		end else if (u_busy_q) begin
			u_cnt_q <= u_cnt_q - 1'b1;
			if (u_div_q) begin
				if (trial >= {1'b0, u_a_q}) begin
					u_acc_q <= UACC_W'(trial - {1'b0, u_a_q});
					u_b_q   <= {u_b_q[61:0], 1'b1};
				end else begin
					u_acc_q <= UACC_W'(trial);
					u_b_q   <= {u_b_q[61:0], 1'b0};
				end
			end else begin
				u_acc_q <= {u_acc_q[79:0], 1'b0} + (u_b_q[39] ? UACC_W'(u_a_q) : '0);
				u_b_q   <= u_b_q << 1;
			end
		end
	end

	// ---------------- memories ----------------
	always_comb begin
		hist_raddr = (rc_q < 3'd4) ? {1'b0, st_q, rc_q[1:0]} : HAW'(16) + HAW'(st_q);
		coef_raddr = CAW'({st_q, 1'b0}) + CAW'(st_q) + ((rc_q < 3'd3) ? CAW'(rc_q) : '0);
		hist_we    = wr_act_q;
		hist_waddr = (wr_cnt_q < 3'd4) ? {1'b0, st_q, wr_cnt_q[1:0]}
			: HAW'(16) + HAW'(st_q);
		case (wr_cnt_q)
			3'd0:    hist_wdata = bq_in_q;
			3'd1:    hist_wdata = h_q[0];
			3'd3:    hist_wdata = h_q[2];
			default: hist_wdata = y_q;
		endcase
		wr_last    = (wr_cnt_q == 3'd4) || (wr_cnt_q == 3'd3 && st_q == 2'd3);
		hist_rdata = hist_rd_vld_q ? $signed(hist_rd_q) : '0;
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		hist_rd_q <= hist_mem[hist_raddr];
		if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
		coef_rd_q <= coef_mem[coef_raddr];
	end

	// history entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q    <= '0;
			hist_rd_vld_q <= 1'b0;
		end else begin
			if (hist_we) hist_vld_q[hist_waddr] <= 1'b1;
			hist_rd_vld_q <= hist_vld_q[hist_raddr];
		end
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		sum_b = MB'(bq_in_q) + (MB'(h_q[0]) <<< 1) + MB'(h_q[1]);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M0: begin
				mul_a = MA'(c_q[0]);
				mul_b = sum_b;
			end
			S_M1: begin
				mul_a = MA'(c_q[1]);
				mul_b = MB'(h_q[2]);
			end
			S_M2: begin
				mul_a = MA'(c_q[2]);
				mul_b = MB'(h_q[3]);
			end
			S_SL: begin
				mul_a = MA'(TRIM_Q24);
				mul_b = MB'(y_q) - MB'(prev_q);
			end
			S_B1: begin
				mul_a = MA'($signed({1'b0, w_cur}));
				mul_b = MB'(wet_q);
			end
			S_B2: begin
				mul_a = MA'($signed(WET_ONE - {1'b0, w_cur}));
				mul_b = MB'(v_q);
			end
			default: ;
		endcase
		prod_w = PW'(mul_a) * PW'(mul_b);
		rcm    = rc_q - 3'd1;
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		logic signed [AW-1:0] vx, hi, lo;
		prod_q <= prod_w;
		vx = AW'(v_q);
		hi = {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
		lo = ~hi;
		case (state_q)
			S_IDLE: if (in_acc) v_q <= sat_ib(AW'(in_sample));
			S_DK2:  if (u_done) k2_q <= u_acc_q[62:23];
			S_DKQ:  if (u_done) kq_q <= u_acc_q[63:30];
			S_DNORM: if (u_done) norm_q <= u_b_q[39:0];
			S_STG:  bq_in_q <= v_q;
			S_RD: begin
				if (rc_q != 3'd0) begin
					if (rcm < 3'd4) h_q[rcm[1:0]] <= hist_rdata;
					else prev_q <= hist_rdata;
					if (rcm < 3'd3) c_q[rcm[1:0]] <= $signed(coef_rd_q);
				end
			end
			S_M1:  acc_q <= AW'(prod_q);
			S_M2:  acc_q <= acc_q - AW'(prod_q);
			S_M3:  acc_q <= acc_q - AW'(prod_q);
			S_Y: begin
				y_q   <= sat_ib(rshr(acc_q, FRAC));
				wet_q <= sat_ib(rshr(acc_q, FRAC));
			end
			S_SL2: wet_q <= sat_ib(rshr(AW'(prod_q), 24));
			S_B2:  acc_q <= AW'(prod_q);
			S_B3:  acc_q <= acc_q + AW'(prod_q);
			S_B4:  v_q <= sat_ib(rshr(acc_q, 15));
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					if (vx > hi) out_q <= hi[SAMPLE_BITS-1:0];
					else if (vx < lo) out_q <= lo[SAMPLE_BITS-1:0];
					else out_q <= vx[SAMPLE_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= '0;
			di_q        <= '0;
			sc_q        <= '0;
			rc_q        <= '0;
			wr_cnt_q    <= '0;
			ph_q        <= 1'b0;
			pending_q   <= 1'b1;
			out_valid_q <= 1'b0;
			wr_act_q    <= 1'b0;
			tan_q       <= TAN_RESET;
			bright_q    <= '0;
			wet_amt_q   <= '{default: '0};
		end else begin
			if (out_ready && state_q != S_FIN) out_valid_q <= 1'b0;
			if (wr_act_q) begin
				wr_cnt_q <= wr_cnt_q + 1'b1;
				if (wr_last) wr_act_q <= 1'b0;
			end
			if (u_start) ph_q <= 1'b1;
			if (u_done) ph_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						st_q    <= '0;
						di_q    <= '0;
						sc_q    <= '0;
						state_q <= pending_q ? S_DK2 : S_STG;
					end
				end
				S_DK2:   if (u_done) state_q <= S_DKQ;
				S_DKQ:   if (u_done) state_q <= S_DNORM;
				S_DNORM: if (u_done) state_q <= S_DSC;
				S_DSC: begin
					if (u_done) begin
						if (sc_q == 2'd2) begin
							sc_q <= '0;
							if (di_q == 2'd3) begin
								state_q <= S_DWET;
							end else begin
								di_q    <= di_q + 1'b1;
								state_q <= S_DKQ;
							end
						end else begin
							sc_q <= sc_q + 1'b1;
						end
					end
				end
				S_DWET: begin
					wet_amt_q[sc_q] <= wprod[50:35];
					if (sc_q == 2'd2) begin
						sc_q      <= '0;
						pending_q <= 1'b0;
						st_q      <= '0;
						state_q   <= S_STG;
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				S_STG: begin
					// skip a disengaged stage
					if (w_cur == '0) begin
						if (st_q == 2'd3) state_q <= S_FIN;
						else st_q <= st_q + 1'b1;
					end else begin
						rc_q    <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					rc_q <= rc_q + 1'b1;
					if (rc_q == 3'd5) state_q <= S_M0;
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_Y;
				S_Y: begin
					// write back history while the slew, if any, and the blend run
					wr_act_q <= 1'b1;
					wr_cnt_q <= '0;
					state_q  <= (st_q == 2'd3) ? S_B1 : S_SL;
				end
				S_SL:  state_q <= S_SL2;
				S_SL2: state_q <= S_B1;
				S_B1:  state_q <= S_B2;
				S_B2:  state_q <= S_B3;
				S_B3:  state_q <= S_B4;
				S_B4: begin
					if (st_q == 2'd3) begin
						state_q <= S_FIN;
					end else begin
						st_q    <= st_q + 1'b1;
						state_q <= S_STG;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CUTOFF: begin
						tan_q     <= cfg_data[TAN_W-1:0];
						pending_q <= 1'b1;
					end
					REG_BRIGHT: begin
						bright_q  <= cfg_data[BRIGHT_W-1:0];
						pending_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// File: test/slew_brightness_biquad_cascade_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_brightness_biquad_cascade_tb
// Drives samples through the cascade under several cutoff and brightness
// settings, mirrors the fixed-point filter math in a scoreboard and compares
// every output sample in order, with random idling and backpressure.
// ----------------------------------------------------------------------------
module slew_brightness_biquad_cascade_tb;
	import sbbc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 150;

	class sample_scoreboard;
		longint unsigned inv_q_q30[4] = '{64'd477860067, 64'd1338934154,
			64'd1934815911, 64'd2147483648};
		bit [31:0]  tangent;
		bit [9:0]   bright;
		bit         stale;
		longint     hist[16];
		longint     prev_lp[3];
		longint     coef[12];
		int         wet[3];
		longint     expected_q[$];
		int         errors;

		function void reset_state();
			tangent = TAN_RESET;
			bright = '0;
			stale = 1'b1;
			foreach (hist[i]) hist[i] = 0;
			foreach (prev_lp[i]) prev_lp[i] = 0;
			foreach (coef[i]) coef[i] = 0;
			foreach (wet[i]) wet[i] = 0;
			expected_q.delete();
			errors = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
			if (idx == REG_CUTOFF) begin
				tangent = data;
				stale = 1'b1;
			end else if (idx == REG_BRIGHT) begin
				bright = data[9:0];
				stale = 1'b1;
			end
		endfunction

		function longint rnd(input longint v, input int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint sat(input longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint norm_mul(input longint num, input longint unsigned nrm);
			longint unsigned mag, p;
			mag = num < 0 ? longint'(-num) : num;
			p = (mag * nrm + (64'd1 << 38)) >> 39;
			return num < 0 ? -longint'(p) : longint'(p);
		endfunction

		function int to_q15(input int unsigned t);
			return (t * 32768 + 500) / 1000;
		endfunction

		function void derive_coefs();
			longint unsigned k, k2, kq, d, nrm;
			int unsigned b, t;
			k = tangent > TAN_MAX ? TAN_MAX : tangent;
			k2 = (k * k) >> 23;
			for (int i = 0; i < 4; i++) begin
				kq = (k * inv_q_q30[i]) >> 30;
				d = 64'd8388608 + kq + k2;
				nrm = (64'd1 << 62) / d;
				coef[3*i]   = norm_mul(longint'(k2), nrm);
				coef[3*i+1] = 2 * norm_mul(longint'(k2) - 8388608, nrm);
				coef[3*i+2] = norm_mul(8388608 - longint'(kq) + longint'(k2), nrm);
			end
			b = bright > BRIGHT_MAX ? 1000 : bright;
			t = 3 * b;
			wet[0] = to_q15(t < 1000 ? t : 1000);
			wet[1] = to_q15(t < 1000 ? 0 : (t < 2000 ? t - 1000 : 1000));
			wet[2] = to_q15(t < 2000 ? 0 : t - 2000);
			stale = 1'b0;
		endfunction

		function longint lowpass(input int n, input longint x);
			longint acc, y;
			acc = coef[3*n] * x + 2 * coef[3*n] * hist[4*n] + coef[3*n] * hist[4*n+1]
				- coef[3*n+1] * hist[4*n+2] - coef[3*n+2] * hist[4*n+3];
			y = sat(rnd(acc, 23));
			hist[4*n+1] = hist[4*n];
			hist[4*n]   = x;
			hist[4*n+3] = hist[4*n+2];
			hist[4*n+2] = y;
			return y;
		endfunction

		function longint slew(input int n, input longint y);
			longint d;
			d = y - prev_lp[n];
			prev_lp[n] = y;
			return sat(rnd(d * 38630967, 24));
		endfunction

		function longint mix(input int w, input longint wet_v, input longint dry);
			return sat(rnd(longint'(w) * wet_v + longint'(32768 - w) * dry, 15));
		endfunction

		function void note_input(input logic signed [23:0] s);
			longint x, v, da, db;
			if (stale) derive_coefs();
			x = s;
			v = x;
			da = 0;
			db = 0;
			if (wet[0] > 0) begin
				v = mix(wet[0], slew(0, lowpass(0, v)), x);
				da = v;
			end
			if (wet[1] > 0) begin
				v = mix(wet[1], slew(1, lowpass(1, v)), da);
				db = v;
			end
			if (wet[2] > 0) v = mix(wet[2], slew(2, lowpass(2, v)), db);
			if (wet[0] > 0) v = mix(wet[0], lowpass(3, v), v);
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			expected_q.push_back(v);
		endfunction

		function void check_output(input logic signed [23:0] s);
			longint want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output sample %0d", s);
				return;
			end
			want = expected_q.pop_front();
			if (longint'(s) != want) begin
				errors++;
				if (errors <= 10)
					$display("out_sample mismatch: expected %0d, got %0d", want, s);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [23:0] in_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] out_sample;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sample_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	slew_brightness_biquad_cascade i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
		.out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// handshake inputs only change at rising edges, so sample them at falling edges
	always begin
		@(negedge clk);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver with random stalls and a long hold-off on request
	always begin
		bit fire;
		logic signed [23:0] got;
		@(negedge clk);
		fire = out_valid && out_ready;
		got = out_sample;
		@(posedge clk);
		if (fire) sb.check_output(got);
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (arst_n) begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
		end
	end

	// valid stays high after the accept unless an idle gap follows; drain drops it
	task automatic send_item(input logic signed [23:0] s);
		in_valid <= 1'b1;
		in_sample <= s;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sb.note_input(s);
		// idle now and then after the accept
		if (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_sample();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return $urandom_range(1) ? 24'sh7fffff : -24'sh800000;
		if (pick < 4) return $signed(24'($urandom_range(8191))) - 24'sd4096;
		return 24'($urandom);
	endfunction

	task automatic run_phase(input logic [31:0] tan_v, input logic [9:0] br, input int n);
		drain();
		write_reg(REG_CUTOFF, tan_v);
		write_reg(REG_BRIGHT, {22'd0, br});
		for (int i = 0; i < n; i++) send_item(rand_sample());
	endtask

	initial begin
		sb.reset_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through with reset settings, extremes of the sample
		send_item(24'sh7fffff);
		send_item(-24'sh800000);
		send_item(24'sd0);
		send_item(-24'sd1);
		send_item(24'sd1);
		drain();
		write_reg(REG_BRIGHT, 32'd1000);
		send_item(24'sh7fffff);
		send_item(24'sh7fffff);
		send_item(-24'sh800000);
		send_item(-24'sh800000);
		send_item(24'sh555555);
		send_item(-24'sh2aaaab);
		send_item(24'sd0);
		drain();
		write_reg(REG_SPARE_A, 32'hffffffff);
		write_reg(REG_SPARE_B, 32'h0);
		send_item(24'sh400000);
		drain();
		write_reg(REG_CUTOFF, 32'hffffffff);
		send_item(24'sh7fffff);
		send_item(-24'sh800000);
		send_item(24'sh7fffff);
		drain();
		write_reg(REG_BRIGHT, 32'd1023);
		write_reg(REG_CUTOFF, 32'd0);
		send_item(24'sh7fffff);
		send_item(-24'sh800000);

		run_phase(TAN_RESET, 10'd1000, 60);
		calm = 1'b1;
		run_phase(32'd300000, 10'd333, 60);
		calm = 1'b0;
		run_phase(TAN_MAX, 10'd500, 30);
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++) send_item(rand_sample());
		drain();
		for (int i = 0; i < 20; i++) send_item(rand_sample());
		run_phase(TAN_MAX + 1, 10'd700, 50);
		run_phase(32'd0, 10'd1, 40);
		run_phase(32'd40000000, 10'd1023, 50);
		run_phase(32'd5000000, 10'd667, 50);
		run_phase(32'($urandom), 10'($urandom_range(1000)), 50);
		run_phase(32'($urandom_range(20000000)), 10'd0, 30);
		run_phase(32'd1677722, 10'd900, 60);

		drain();
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
